[design/frustum_box_culling_defines.svh]
// Assertion macros shared by the frustum box culling design files.
`ifndef FRUSTUM_BOX_CULLING_DEFINES_SVH
`define FRUSTUM_BOX_CULLING_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define FBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frustum box culling assertion failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define FBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frustum box culling assertion failed");
`else
`define FBC_ASSERT_IMP(lbl, ante, cons)
`define FBC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[design/fbc_pkg.sv]
// Shared types and constants of the frustum box culling block.
package fbc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ACC_W     = 128;
  localparam int unsigned MEM_DEPTH = 64;
  localparam int unsigned MEM_AW    = 6;

  // Command codes.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_TEST  = 2'd2;

  // Memory map: matrix at 0..15, planes at 16..39, corners at 40..63.
  localparam logic [MEM_AW-1:0] PLANE_BASE  = 6'd16;
  localparam logic [MEM_AW-1:0] CORNER_BASE = 6'd40;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } fbc_in_t;

  typedef struct packed {
    logic visible;
    logic degenerate;
  } fbc_out_t;

endpackage

[design/fbc_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module fbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/frustum_box_culling.sv]
// Frustum box culling: a load gives no result, busy stays low.
// Build forms the planes, then per corner the determinant and, unless it is zero,
// per component a numerator and a restoring division of 128 divider steps.
// Test checks the planes, then the corners, and stops early on a plane cull.
// Matrix, planes and corners sit in one RAM with a read and a write port, used one access a cycle.
// Reset is asynchronous; planes and corners read as zero until the first build.
`include "frustum_box_culling_defines.svh"
module frustum_box_culling #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  fbc_pkg::fbc_in_t  in_i,
  output logic              busy,
  output logic              done_o,
  output fbc_pkg::fbc_out_t out_o
);

  import fbc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PL_R3, ST_PL_RK, ST_PL_WR,
    ST_TR_U, ST_TR_V, ST_TR_W, ST_TR_M1, ST_TR_M2, ST_TR_A2, ST_TR_A3,
    ST_SET_END, ST_DIV, ST_DIV_WR, ST_ZERO_WR,
    ST_TP_RD, ST_TP_MUL, ST_TP_ACC, ST_TP_CHK, ST_TC, ST_TC_END
  } state_e;

  typedef struct packed {
    logic              neg;
    logic [MEM_AW-1:0] ua;
    logic [MEM_AW-1:0] va;
    logic [MEM_AW-1:0] wa;
  } term_t;

  // Next index modulo three.
  function automatic logic [1:0] nxt3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

  // Address of coefficient k of plane p.
  function automatic logic [MEM_AW-1:0] caddr(input logic [2:0] p, input logic [1:0] k);
    return PLANE_BASE + {1'b0, p, k};
  endfunction

  // Address of component k of corner c.
  function automatic logic [MEM_AW-1:0] kaddr(input logic [2:0] c, input logic [1:0] k);
    return CORNER_BASE + {2'b00, c, 1'b0} + {3'b000, c} + {4'b0000, k};
  endfunction

  // Triple product t of set s for corner c: s zero is the determinant,
  // otherwise the Cramer numerator of component s minus one.
  function automatic term_t term_sel(input logic [2:0] c, input logic [1:0] s,
                                     input logic [2:0] t);
    logic [2:0] pa, pb, pe;
    logic [1:0] i, j, l;
    term_t      r;
    pa = {2'b00, c[1]};
    pb = 3'd2 + {2'b00, c[0]};
    pe = 3'd4 + {2'b00, c[2]};
    i  = (s == 2'd0) ? t[2:1] : s - 2'd1;
    j  = nxt3(i);
    l  = nxt3(j);
    r  = '0;
    if (s == 2'd0) begin
      r.neg = t[0];
      r.ua  = caddr(pa, i);
      r.va  = caddr(pb, t[0] ? l : j);
      r.wa  = caddr(pe, t[0] ? j : l);
    end else begin
      case (t)
        3'd0: begin
          r.neg = 1'b0; r.ua = caddr(pa, 2'd3); r.va = caddr(pb, j); r.wa = caddr(pe, l);
        end
        3'd1: begin
          r.neg = 1'b1; r.ua = caddr(pa, 2'd3); r.va = caddr(pb, l); r.wa = caddr(pe, j);
        end
        3'd2: begin
          r.neg = 1'b1; r.ua = caddr(pb, 2'd3); r.va = caddr(pa, j); r.wa = caddr(pe, l);
        end
        3'd3: begin
          r.neg = 1'b0; r.ua = caddr(pb, 2'd3); r.va = caddr(pa, l); r.wa = caddr(pe, j);
        end
        3'd4: begin
          r.neg = 1'b0; r.ua = caddr(pe, 2'd3); r.va = caddr(pa, j); r.wa = caddr(pb, l);
        end
        default: begin
          r.neg = 1'b1; r.ua = caddr(pe, 2'd3); r.va = caddr(pa, l); r.wa = caddr(pb, j);
        end
      endcase
    end
    return r;
  endfunction

  // Registers.
  state_e                    state_q, state_d;
  logic                      built_q, built_d;
  logic                      zero_q, zero_d;
  logic [2:0]                p_q, p_d;
  logic [1:0]                k_q, k_d;
  logic [2:0]                c_q, c_d;
  logic [1:0]                s_q, s_d;
  logic [2:0]                t_q, t_d;
  logic signed [31:0]        opa_q, opa_d, opb_q, opb_d, opc_q, opc_d;
  logic [31:0]               lo_q, lo_d;
  logic signed [65:0]        mul_q, mul_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [ACC_W-1:0]          dabs_q, dabs_d;
  logic                      dneg_q, dneg_d;
  logic [ACC_W-1:0]          num_q, num_d;
  logic [ACC_W-1:0]          rem_q, rem_d;
  logic [32:0]               quo_q, quo_d;
  logic                      ovf_q, ovf_d;
  logic                      qneg_q, qneg_d;
  logic [6:0]                cnt_q, cnt_d;
  logic                      degen_q, degen_d;
  logic signed [31:0]        lo_b_q [3], lo_b_d [3];
  logic signed [31:0]        hi_b_q [3], hi_b_d [3];
  logic signed [31:0]        mx_b_q [3], mx_b_d [3];
  logic signed [31:0]        mn_b_q [3], mn_b_d [3];
  logic [4:0]                j_q, j_d;
  logic [1:0]                ax_q, ax_d, axp_q, axp_d;
  logic                      tv_q, tv_d;
  logic [2:0]                above_q, above_d, below_q, below_d;
  logic                      done_q, done_d;
  fbc_out_t                  out_q, out_d;

  // Memory port and shared datapath signals.
  logic                      ram_we;
  logic [MEM_AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_W-1:0]         ram_wdata, ram_rdata;
  logic signed [31:0]        rd_val;
  logic signed [32:0]        mul_a, mul_b;
  logic signed [65:0]        mul_p;
  term_t                     tm;
  logic signed [32:0]        pl_sum;
  logic [31:0]               pl_sat;
  logic [ACC_W-1:0]          acc_abs;
  logic [ACC_W-1:0]          rem_sh;
  logic                      rem_ge;
  logic                      q_big;
  logic [31:0]               q_sat;
  logic signed [ACC_W-1:0]   mul_ext, mul_ext_hi, d_ext;

  fbc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Plane and corner entries read as zero until the first build.
  assign rd_val = zero_q ? 32'sd0 : $signed(ram_rdata);

  // Shared signed multiplier.
  assign mul_p = mul_a * mul_b;

  assign tm = term_sel(c_q, s_q, t_q);

  // Saturating plane sum or difference.
  assign pl_sum = p_q[0] ? ({opa_q[31], opa_q} - {rd_val[31], rd_val})
                         : ({opa_q[31], opa_q} + {rd_val[31], rd_val});
  assign pl_sat = (pl_sum[32] != pl_sum[31]) ? (pl_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                             : pl_sum[31:0];

  assign acc_abs    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign mul_ext    = {{(ACC_W-66){mul_q[65]}}, mul_q};
  assign mul_ext_hi = {{(ACC_W-98){mul_q[65]}}, mul_q, 32'h0};
  assign d_ext      = {{(ACC_W-32){rd_val[31]}}, rd_val} <<< FRAC_BITS;

  // One restoring division step.
  assign rem_sh = {rem_q[ACC_W-2:0], num_q[ACC_W-1]};
  assign rem_ge = (rem_sh >= dabs_q);

  // Saturated signed quotient.
  assign q_big = ovf_q | quo_q[32] | quo_q[31];
  assign q_sat = qneg_q ? (q_big ? 32'h8000_0000 : 32'(-quo_q[31:0]))
                        : (q_big ? 32'h7FFF_FFFF : quo_q[31:0]);

  // Sequencer.
  always_comb begin
    state_d = state_q;   built_d = built_q;   p_d = p_q;       k_d = k_q;
    c_d = c_q;           s_d = s_q;           t_d = t_q;       opa_d = opa_q;
    opb_d = opb_q;       opc_d = opc_q;       lo_d = lo_q;     mul_d = mul_q;
    acc_d = acc_q;       dabs_d = dabs_q;     dneg_d = dneg_q; num_d = num_q;
    rem_d = rem_q;       quo_d = quo_q;       ovf_d = ovf_q;   qneg_d = qneg_q;
    cnt_d = cnt_q;       degen_d = degen_q;   j_d = j_q;       ax_d = ax_q;
    axp_d = axp_q;       tv_d = tv_q;         above_d = above_q;
    below_d = below_q;   done_d = 1'b0;       out_d = out_q;
    lo_b_d = lo_b_q;     hi_b_d = hi_b_q;     mx_b_d = mx_b_q; mn_b_d = mn_b_q;
    ram_we = 1'b0;       ram_waddr = '0;      ram_wdata = '0;  ram_raddr = '0;
    mul_a = '0;          mul_b = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (in_i.cmd)
            CMD_LOAD: begin
              ram_we    = 1'b1;
              ram_waddr = {2'b00, in_i.entry_index};
              ram_wdata = in_i.entry_value;
            end
            CMD_BUILD: begin
              built_d = 1'b1;
              degen_d = 1'b0;
              p_d     = '0;
              k_d     = '0;
              state_d = ST_PL_R3;
            end
            CMD_TEST: begin
              lo_b_d[0] = in_i.box_min_x;
              lo_b_d[1] = in_i.box_min_y;
              lo_b_d[2] = in_i.box_min_z;
              hi_b_d[0] = in_i.box_max_x;
              hi_b_d[1] = in_i.box_max_y;
              hi_b_d[2] = in_i.box_max_z;
              for (int i = 0; i < 3; i++) begin
                mx_b_d[i] = (lo_b_d[i] > hi_b_d[i]) ? lo_b_d[i] : hi_b_d[i];
                mn_b_d[i] = (lo_b_d[i] > hi_b_d[i]) ? hi_b_d[i] : lo_b_d[i];
              end
              p_d     = '0;
              k_d     = '0;
              acc_d   = '0;
              state_d = ST_TP_RD;
            end
            default: begin
            end
          endcase
        end
      end

      // Plane formation: row three plus or minus row p/2.
      ST_PL_R3: begin
        ram_raddr = {2'b00, 2'b11, k_q};
        state_d   = ST_PL_RK;
      end
      ST_PL_RK: begin
        ram_raddr = {2'b00, p_q[2:1], k_q};
        opa_d     = rd_val;
        state_d   = ST_PL_WR;
      end
      ST_PL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = caddr(p_q, k_q);
        ram_wdata = pl_sat;
        k_d       = k_q + 2'd1;
        state_d   = ST_PL_R3;
        if (k_q == 2'd3) begin
          if (p_q == 3'd5) begin
            c_d     = '0;
            s_d     = '0;
            t_d     = '0;
            acc_d   = '0;
            state_d = ST_TR_U;
          end else begin
            p_d = p_q + 3'd1;
          end
        end
      end

      // Exact triple product u*v*w accumulated in pieces.
      ST_TR_U: begin
        ram_raddr = tm.ua;
        state_d   = ST_TR_V;
      end
      ST_TR_V: begin
        ram_raddr = tm.va;
        opa_d     = rd_val;
        state_d   = ST_TR_W;
      end
      ST_TR_W: begin
        ram_raddr = tm.wa;
        opb_d     = rd_val;
        state_d   = ST_TR_M1;
      end
      ST_TR_M1: begin
        opc_d   = rd_val;
        mul_a   = {opa_q[31], opa_q};
        mul_b   = {opb_q[31], opb_q};
        mul_d   = mul_p;
        state_d = ST_TR_M2;
      end
      ST_TR_M2: begin
        lo_d    = mul_q[31:0];
        mul_a   = {mul_q[63], mul_q[63:32]};
        mul_b   = {opc_q[31], opc_q};
        mul_d   = mul_p;
        state_d = ST_TR_A2;
      end
      ST_TR_A2: begin
        acc_d   = tm.neg ? (acc_q - mul_ext_hi) : (acc_q + mul_ext_hi);
        mul_a   = {1'b0, lo_q};
        mul_b   = {opc_q[31], opc_q};
        mul_d   = mul_p;
        state_d = ST_TR_A3;
      end
      ST_TR_A3: begin
        acc_d = tm.neg ? (acc_q - mul_ext) : (acc_q + mul_ext);
        if (t_q == 3'd5) begin
          t_d     = '0;
          state_d = ST_SET_END;
        end else begin
          t_d     = t_q + 3'd1;
          state_d = ST_TR_U;
        end
      end

      // A determinant or a numerator is complete.
      ST_SET_END: begin
        if (s_q == 2'd0) begin
          if (acc_q == '0) begin
            degen_d = 1'b1;
            k_d     = '0;
            state_d = ST_ZERO_WR;
          end else begin
            dabs_d  = acc_abs;
            dneg_d  = acc_q[ACC_W-1];
            s_d     = 2'd1;
            acc_d   = '0;
            state_d = ST_TR_U;
          end
        end else begin
          qneg_d  = (!acc_q[ACC_W-1] && (acc_q != '0)) ^ dneg_q;
          num_d   = acc_abs << FRAC_BITS;
          rem_d   = '0;
          quo_d   = '0;
          ovf_d   = 1'b0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = rem_ge ? (rem_sh - dabs_q) : rem_sh;
        num_d = {num_q[ACC_W-2:0], 1'b0};
        quo_d = {quo_q[31:0], rem_ge};
        ovf_d = ovf_q | quo_q[32];
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          state_d = ST_DIV_WR;
        end
      end
      ST_DIV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = kaddr(c_q, s_q - 2'd1);
        ram_wdata = q_sat;
        acc_d     = '0;
        t_d       = '0;
        state_d   = ST_TR_U;
        if (s_q == 2'd3) begin
          s_d = '0;
          if (c_q == 3'd7) begin
            done_d  = 1'b1;
            out_d   = '{visible: 1'b0, degenerate: degen_q};
            state_d = ST_IDLE;
          end else begin
            c_d = c_q + 3'd1;
          end
        end else begin
          s_d = s_q + 2'd1;
        end
      end
      ST_ZERO_WR: begin
        ram_we    = 1'b1;
        ram_waddr = kaddr(c_q, k_q);
        ram_wdata = '0;
        k_d       = k_q + 2'd1;
        if (k_q == 2'd2) begin
          k_d   = '0;
          acc_d = '0;
          t_d   = '0;
          s_d   = '0;
          if (c_q == 3'd7) begin
            done_d  = 1'b1;
            out_d   = '{visible: 1'b0, degenerate: degen_q};
            state_d = ST_IDLE;
          end else begin
            c_d     = c_q + 3'd1;
            state_d = ST_TR_U;
          end
        end
      end

      // Plane test: largest value of the plane over the box.
      ST_TP_RD: begin
        ram_raddr = caddr(p_q, k_q);
        state_d   = ST_TP_MUL;
      end
      ST_TP_MUL: begin
        if (k_q == 2'd3) begin
          acc_d   = acc_q + d_ext;
          state_d = ST_TP_CHK;
        end else begin
          mul_a   = {rd_val[31], rd_val};
          mul_b   = rd_val[31] ? {mn_b_q[k_q][31], mn_b_q[k_q]}
                               : {mx_b_q[k_q][31], mx_b_q[k_q]};
          mul_d   = mul_p;
          state_d = ST_TP_ACC;
        end
      end
      ST_TP_ACC: begin
        acc_d   = acc_q + mul_ext;
        k_d     = k_q + 2'd1;
        state_d = ST_TP_RD;
      end
      ST_TP_CHK: begin
        if (acc_q[ACC_W-1]) begin
          done_d  = 1'b1;
          out_d   = '{visible: 1'b0, degenerate: 1'b0};
          state_d = ST_IDLE;
        end else begin
          acc_d = '0;
          k_d   = '0;
          if (p_q == 3'd5) begin
            j_d     = '0;
            ax_d    = '0;
            tv_d    = 1'b0;
            above_d = '1;
            below_d = '1;
            state_d = ST_TC;
          end else begin
            p_d     = p_q + 3'd1;
            state_d = ST_TP_RD;
          end
        end
      end

      // Corner test: stream the 24 corner components against the box faces.
      ST_TC: begin
        ram_raddr = CORNER_BASE + {1'b0, j_q};
        if (tv_q) begin
          above_d[axp_q] = above_q[axp_q] & (rd_val > hi_b_q[axp_q]);
          below_d[axp_q] = below_q[axp_q] & (rd_val < lo_b_q[axp_q]);
        end
        if (j_q != 5'd24) begin
          j_d   = j_q + 5'd1;
          ax_d  = nxt3(ax_q);
          axp_d = ax_q;
          tv_d  = 1'b1;
        end else begin
          tv_d    = 1'b0;
          state_d = ST_TC_END;
        end
      end
      ST_TC_END: begin
        done_d  = 1'b1;
        out_d   = '{visible: !((|above_q) || (|below_q)), degenerate: 1'b0};
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The read of the coming cycle is forced to zero before the first build.
  assign zero_d = !built_q && (ram_raddr >= PLANE_BASE);

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;  built_q <= 1'b0;  zero_q <= 1'b0;  p_q <= '0;
      k_q <= '0;           c_q <= '0;        s_q <= '0;       t_q <= '0;
      opa_q <= '0;         opb_q <= '0;      opc_q <= '0;     lo_q <= '0;
      mul_q <= '0;         acc_q <= '0;      dabs_q <= '0;    dneg_q <= 1'b0;
      num_q <= '0;         rem_q <= '0;      quo_q <= '0;     ovf_q <= 1'b0;
      qneg_q <= 1'b0;      cnt_q <= '0;      degen_q <= 1'b0; j_q <= '0;
      ax_q <= '0;          axp_q <= '0;      tv_q <= 1'b0;    above_q <= '0;
      below_q <= '0;       done_q <= 1'b0;   out_q <= '0;
      for (int i = 0; i < 3; i++) begin
        lo_b_q[i] <= '0;
        hi_b_q[i] <= '0;
        mx_b_q[i] <= '0;
        mn_b_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;  built_q <= built_d;  zero_q <= zero_d;  p_q <= p_d;
      k_q <= k_d;          c_q <= c_d;          s_q <= s_d;        t_q <= t_d;
      opa_q <= opa_d;      opb_q <= opb_d;      opc_q <= opc_d;    lo_q <= lo_d;
      mul_q <= mul_d;      acc_q <= acc_d;      dabs_q <= dabs_d;  dneg_q <= dneg_d;
      num_q <= num_d;      rem_q <= rem_d;      quo_q <= quo_d;    ovf_q <= ovf_d;
      qneg_q <= qneg_d;    cnt_q <= cnt_d;      degen_q <= degen_d; j_q <= j_d;
      ax_q <= ax_d;        axp_q <= axp_d;      tv_q <= tv_d;      above_q <= above_d;
      below_q <= below_d;  done_q <= done_d;    out_q <= out_d;
      lo_b_q <= lo_b_d;    hi_b_q <= hi_b_d;    mx_b_q <= mx_b_d;  mn_b_q <= mn_b_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign out_o  = out_q;

  // A result only closes a command that kept the block busy.
  `FBC_ASSERT_IMP(a_done_after_busy, done_o, $past(busy))
  // A load is absorbed at once and gives no result.
  `FBC_ASSERT_NXT(a_load_no_result, start && !busy && (in_i.cmd == CMD_LOAD), !busy && !done_o)
  // Build and test always occupy the sequencer.
  `FBC_ASSERT_NXT(a_cmd_busy, start && !busy && ((in_i.cmd == CMD_BUILD) || (in_i.cmd == CMD_TEST)), busy)
  // A test result never flags degeneracy and a build never flags visibility.
  `FBC_ASSERT_IMP(a_one_flag, done_o, !(out_o.visible && out_o.degenerate))

endmodule
